FILE: design/sstd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sstd_pkg: shared constants of the sample to decimal text converter
// Widths, register indexes, reset values and character codes.
// ---------------------------------------------------------------------------
package sstd_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int FIELD_BITS  = 10;
    localparam int CFG_BITS    = 18;
    localparam int GAIN_BITS   = 18;
    localparam int FRAC_BITS   = 24;
    localparam int ABS_BITS    = (SAMPLE_BITS + 8 > CFG_BITS) ? SAMPLE_BITS + 8 : CFG_BITS;
    localparam int PROD_BITS   = ABS_BITS + GAIN_BITS;
    localparam int MAG_BITS    = PROD_BITS - FRAC_BITS;
    localparam int DIV_BITS    = 15;
    localparam int MAG_LIMIT   = 32767;
    localparam int MAX_DIGITS  = 11;
    localparam int BIN_LIMIT   = (1 << MAX_DIGITS) - 1;
    localparam int CNT_BITS    = $clog2(GAIN_BITS + 1);
    localparam int ND_BITS     = $clog2(MAX_DIGITS + 1);
    localparam int IDX_BITS    = $clog2(MAX_DIGITS);

    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_GAIN   = 2'd1;
    localparam logic [1:0] REG_RADIX  = 2'd2;

    localparam logic [CFG_BITS-1:0] OFFSET_RESET = 18'd83023;
    localparam logic [CFG_BITS-1:0] GAIN_RESET   = 18'd53718;
    localparam logic [3:0]          RADIX_RESET  = 4'd10;

    localparam logic [3:0] BASE_MIN = 4'd2;
    localparam logic [3:0] BASE_DEC = 4'd10;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;

endpackage

FILE: design/sensor_sample_to_decimal_text.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sensor_sample_to_decimal_text: converter sample to a line of ASCII digits
// Scales a sample with offset and reciprocal gain, then emits its digits in
// the configured base, most significant first, followed by CR and LF.
// ---------------------------------------------------------------------------
// Channel   Handshake                 Payload
// input     start, busy               i_adc_sample
// result    o_valid (strobe)          o_text_char, o_last
// config    i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// An item passes through the shift-add multiplier, then the restoring divider
// for each digit, then sends its characters. A negative value is led by a
// minus sign in base 10; in any other base it gives no digits, only CR, LF.
// Reset is synchronous and restores the register defaults. Results cannot
// be stalled; busy falls in the cycle that carries the LF, so the next item
// can start there.
// ---------------------------------------------------------------------------
module sensor_sample_to_decimal_text (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [sstd_pkg::FIELD_BITS-1:0]    i_adc_sample,
    output logic                               o_valid,
    output logic [7:0]                         o_text_char,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [sstd_pkg::CFG_BITS-1:0]      i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIV, S_SIGN, S_DIG, S_CR, S_LF
    } t_state;

    t_state                            r_state;
    logic [sstd_pkg::CFG_BITS-1:0]     r_offset;
    logic [sstd_pkg::CFG_BITS-1:0]     r_gain;
    logic [3:0]                        r_radix;
    logic [3:0]                        r_base;
    logic                              r_neg;
    logic [sstd_pkg::ABS_BITS-1:0]     r_mcand;
    logic [sstd_pkg::GAIN_BITS-1:0]    r_mplier;
    logic [sstd_pkg::PROD_BITS-1:0]    r_acc;
    logic [sstd_pkg::CNT_BITS-1:0]     r_cnt;
    logic [sstd_pkg::DIV_BITS-1:0]     r_quo;
    logic [3:0]                        r_rem;
    logic [sstd_pkg::ND_BITS-1:0]      r_nd;
    logic [3:0]                        r_dig [sstd_pkg::MAX_DIGITS];

    logic [sstd_pkg::SAMPLE_BITS-1:0]  n_sample;
    logic [sstd_pkg::ABS_BITS:0]       n_diff;
    logic [sstd_pkg::ABS_BITS-1:0]     n_abs;
    logic [3:0]                        n_base;
    logic [sstd_pkg::ABS_BITS:0]       n_sum;
    logic [sstd_pkg::PROD_BITS-1:0]    n_prod;
    logic [sstd_pkg::MAG_BITS-1:0]     n_mag_full;
    logic [sstd_pkg::DIV_BITS-1:0]     n_mag;
    logic [4:0]                        n_trial;
    logic                              n_qbit;
    logic [3:0]                        n_rem;
    logic [sstd_pkg::DIV_BITS-1:0]     n_quo;
    logic [sstd_pkg::IDX_BITS-1:0]     n_top;

    function automatic logic [sstd_pkg::ABS_BITS-1:0] n_abs_neg(
        input logic [sstd_pkg::ABS_BITS:0] value
    );
        logic [sstd_pkg::ABS_BITS:0] neg_value;
        neg_value = -value;
        return neg_value[sstd_pkg::ABS_BITS-1:0];
    endfunction

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_sample = sstd_pkg::SAMPLE_BITS'(i_adc_sample);
        n_diff   = {1'b0, (sstd_pkg::ABS_BITS)'({n_sample, 8'd0})}
                 - {1'b0, (sstd_pkg::ABS_BITS)'(r_offset)};
        n_abs    = n_diff[sstd_pkg::ABS_BITS] ? n_abs_neg(n_diff) : n_diff[sstd_pkg::ABS_BITS-1:0];
        if (r_radix < sstd_pkg::BASE_MIN) begin
            n_base = sstd_pkg::BASE_MIN;
        end else if (r_radix > sstd_pkg::BASE_DEC) begin
            n_base = sstd_pkg::BASE_DEC;
        end else begin
            n_base = r_radix;
        end

        n_sum  = {1'b0, r_acc[sstd_pkg::PROD_BITS-1:sstd_pkg::GAIN_BITS]}
               + (r_mplier[0] ? {1'b0, r_mcand} : '0);
        n_prod = {n_sum, r_acc[sstd_pkg::GAIN_BITS-1:1]};
        n_mag_full = n_prod[sstd_pkg::PROD_BITS-1:sstd_pkg::FRAC_BITS];
        if (n_mag_full > sstd_pkg::MAG_LIMIT) begin
            n_mag = sstd_pkg::DIV_BITS'(sstd_pkg::MAG_LIMIT);
        end else begin
            n_mag = sstd_pkg::DIV_BITS'(n_mag_full);
        end
        if (r_base == sstd_pkg::BASE_MIN && n_mag > sstd_pkg::BIN_LIMIT) begin
            n_mag = sstd_pkg::DIV_BITS'(sstd_pkg::BIN_LIMIT);
        end

        n_trial = {r_rem, r_quo[sstd_pkg::DIV_BITS-1]};
        n_qbit  = (n_trial >= {1'b0, r_base});
        n_rem   = n_qbit ? 4'(n_trial - {1'b0, r_base}) : n_trial[3:0];
        n_quo   = {r_quo[sstd_pkg::DIV_BITS-2:0], n_qbit};
        n_top   = sstd_pkg::IDX_BITS'(r_nd - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_offset    <= sstd_pkg::OFFSET_RESET;
            r_gain      <= sstd_pkg::GAIN_RESET;
            r_radix     <= sstd_pkg::RADIX_RESET;
            r_cnt       <= '0;
            r_nd        <= '0;
            o_valid     <= 1'b0;
            o_last      <= 1'b0;
            o_text_char <= '0;
        end else begin
            o_valid <= 1'b0;
            o_last  <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sstd_pkg::REG_OFFSET: r_offset <= i_cfg_data;
                    sstd_pkg::REG_GAIN:   r_gain   <= i_cfg_data;
                    sstd_pkg::REG_RADIX:  r_radix  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mcand  <= n_abs;
                        r_neg    <= n_diff[sstd_pkg::ABS_BITS];
                        r_mplier <= r_gain;
                        r_acc    <= '0;
                        r_base   <= n_base;
                        r_cnt    <= '0;
                        r_nd     <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc    <= n_prod;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == sstd_pkg::CNT_BITS'(sstd_pkg::GAIN_BITS - 1)) begin
                        r_cnt <= '0;
                        r_quo <= n_mag;
                        r_rem <= '0;
                        r_neg <= r_neg && (n_mag != '0);
                        if (r_neg && n_mag != '0 && r_base != sstd_pkg::BASE_DEC) begin
                            r_state <= S_CR;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == sstd_pkg::CNT_BITS'(sstd_pkg::DIV_BITS - 1)) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_dig[sstd_pkg::IDX_BITS'(r_nd)] <= n_rem;
                        r_nd  <= r_nd + 1'b1;
                        if (n_quo == '0) begin
                            r_state <= r_neg ? S_SIGN : S_DIG;
                        end
                    end
                end
                S_SIGN: begin
                    o_valid     <= 1'b1;
                    o_text_char <= sstd_pkg::CH_MINUS;
                    r_state     <= S_DIG;
                end
                S_DIG: begin
                    o_valid     <= 1'b1;
                    o_text_char <= sstd_pkg::CH_ZERO + {4'd0, r_dig[n_top]};
                    r_nd        <= r_nd - 1'b1;
                    if (r_nd == sstd_pkg::ND_BITS'(1)) begin
                        r_state <= S_CR;
                    end
                end
                S_CR: begin
                    o_valid     <= 1'b1;
                    o_text_char <= sstd_pkg::CH_CR;
                    r_state     <= S_LF;
                end
                S_LF: begin
                    o_valid     <= 1'b1;
                    o_last      <= 1'b1;
                    o_text_char <= sstd_pkg::CH_LF;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_valid && o_text_char == sstd_pkg::CH_LF))
        else $error("last flag not on an LF result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nd <= sstd_pkg::ND_BITS'(sstd_pkg::MAX_DIGITS))
        else $error("digit stack overflow");

    a_dig_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG || r_state == S_SIGN) |-> (r_nd != '0))
        else $error("digit output with empty stack");

    a_lf_after_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CR) |=> (r_state == S_LF && o_valid && o_text_char == sstd_pkg::CH_CR))
        else $error("CR not followed by LF");

endmodule

FILE: tb/sv/sensor_sample_to_decimal_text_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sensor_sample_to_decimal_text_tb: self-checking bench for the text converter
// A queue of samples and register writes feeds a clocked driver that sends
// items in bursts with random gaps. Register writes go in only once the line
// in flight has drained. Each accepted sample is scaled and spelled out by a
// local predictor, and a clocked monitor checks every character against it.
// ---------------------------------------------------------------------------
module sensor_sample_to_decimal_text_tb;

    localparam logic [1:0] REG_NONE      = 2'd3;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         DRAIN_CYCLES  = 250;
    localparam longint     TIMEOUT_NS    = 3_000_000;
    localparam int         PHASES        = 7;
    localparam int         PHASE_ITEMS   = 17;

    typedef struct {
        bit                                  is_write;
        logic [1:0]                          index;
        logic [sstd_pkg::CFG_BITS-1:0]       data;
        logic [sstd_pkg::FIELD_BITS-1:0]     sample;
    } t_work;

    typedef struct {
        logic [7:0] text_char;
        logic       last;
    } t_text_char;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [sstd_pkg::FIELD_BITS-1:0] i_adc_sample = '0;
    logic                            o_valid;
    logic [7:0]                      o_text_char;
    logic                            o_last;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [1:0]                      i_cfg_index = '0;
    logic [sstd_pkg::CFG_BITS-1:0]   i_cfg_data = '0;

    t_work      work_q[$];
    t_text_char text_q[$];

    logic [sstd_pkg::CFG_BITS-1:0] cfg_offset = sstd_pkg::OFFSET_RESET;
    logic [sstd_pkg::CFG_BITS-1:0] cfg_gain   = sstd_pkg::GAIN_RESET;
    logic [3:0]                    cfg_radix  = sstd_pkg::RADIX_RESET;

    int err_count    = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int quiet_cycles = 0;
    logic nxt_start;
    logic nxt_cfg_valid;
    t_text_char got;

    sensor_sample_to_decimal_text dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_adc_sample (i_adc_sample),
        .o_valid      (o_valid),
        .o_text_char  (o_text_char),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic apply_register(input logic [1:0] index,
                                  input logic [sstd_pkg::CFG_BITS-1:0] data);
        case (index)
            sstd_pkg::REG_OFFSET: begin
                cfg_offset = data;
            end
            sstd_pkg::REG_GAIN: begin
                cfg_gain = data;
            end
            sstd_pkg::REG_RADIX: begin
                cfg_radix = data[3:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic predict_text_line(input logic [sstd_pkg::FIELD_BITS-1:0] sample);
        longint diff;
        longint prod;
        longint mag;
        longint span;
        int     base;
        int     nd;
        int     i;
        bit     neg;
        int     digit_buf[sstd_pkg::MAX_DIGITS];
        diff = longint'(sample & ((1 << sstd_pkg::SAMPLE_BITS) - 1)) * 256
             - longint'(cfg_offset);
        prod = diff * longint'(cfg_gain);
        neg  = (prod < 0);
        mag  = (neg ? -prod : prod) >> sstd_pkg::FRAC_BITS;
        if (mag > sstd_pkg::MAG_LIMIT) mag = sstd_pkg::MAG_LIMIT;
        if (mag == 0) neg = 1'b0;
        if (cfg_radix < sstd_pkg::BASE_MIN) begin
            base = int'(sstd_pkg::BASE_MIN);
        end else if (cfg_radix > sstd_pkg::BASE_DEC) begin
            base = int'(sstd_pkg::BASE_DEC);
        end else begin
            base = int'(cfg_radix);
        end
        span = 1;
        for (i = 0; i < sstd_pkg::MAX_DIGITS; i++) span = span * base;
        if (mag > span - 1) mag = span - 1;
        nd = 0;
        if (mag == 0) begin
            text_q.push_back('{sstd_pkg::CH_ZERO, 1'b0});
        end else if (!neg || base == int'(sstd_pkg::BASE_DEC)) begin
            while (mag > 0) begin
                digit_buf[nd] = int'(mag % base);
                mag = mag / base;
                nd++;
            end
            if (neg) text_q.push_back('{sstd_pkg::CH_MINUS, 1'b0});
            for (i = nd - 1; i >= 0; i--) begin
                text_q.push_back('{sstd_pkg::CH_ZERO + 8'(digit_buf[i]), 1'b0});
            end
        end
        text_q.push_back('{sstd_pkg::CH_CR, 1'b0});
        text_q.push_back('{sstd_pkg::CH_LF, 1'b1});
    endtask

    // Driver: sends queued samples in bursts and holds register writes until the block is idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_cfg_valid  <= 1'b0;
            burst_left   = 0;
            gap_left     = 0;
            quiet_cycles = 0;
        end else begin
            nxt_start     = start;
            nxt_cfg_valid = i_cfg_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
                void'(work_q.pop_front());
                nxt_cfg_valid = 1'b0;
            end
            if (start && !busy) begin
                predict_text_line(i_adc_sample);
                void'(work_q.pop_front());
                nxt_start = 1'b0;
                if (burst_left > 0) burst_left--;
            end
            if (text_q.size() == 0 && !busy && !start && !o_valid) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
            if (!nxt_start && !nxt_cfg_valid && work_q.size() > 0) begin
                if (work_q[0].is_write) begin
                    if (quiet_cycles >= SETTLE_CYCLES) begin
                        nxt_cfg_valid = 1'b1;
                        i_cfg_index   <= work_q[0].index;
                        i_cfg_data    <= work_q[0].data;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(20, 200);
                        default: gap_left = $urandom_range(1, 20);
                    endcase
                end else begin
                    nxt_start = 1'b1;
                    i_adc_sample <= work_q[0].sample;
                end
            end
            start       <= nxt_start;
            i_cfg_valid <= nxt_cfg_valid;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (text_q.size() == 0) begin
                $error("text_char: expected none, actual %0d (last %0b)", o_text_char, o_last);
                err_count++;
            end else begin
                got = text_q.pop_front();
                if (o_text_char !== got.text_char) begin
                    $error("text_char: expected %0d, actual %0d", got.text_char, o_text_char);
                    err_count++;
                end
                if (o_last !== got.last) begin
                    $error("last: expected %0b, actual %0b", got.last, o_last);
                    err_count++;
                end
            end
        end
    end

    logic [sstd_pkg::CFG_BITS-1:0] gen_offset = sstd_pkg::OFFSET_RESET;

    task automatic queue_sample(input int sample);
        work_q.push_back('{1'b0, REG_NONE, '0, sstd_pkg::FIELD_BITS'(sample)});
    endtask

    task automatic queue_write(input logic [1:0] index,
                               input logic [sstd_pkg::CFG_BITS-1:0] data);
        if (index == sstd_pkg::REG_OFFSET) gen_offset = data;
        work_q.push_back('{1'b1, index, data, '0});
    endtask

    function automatic logic [sstd_pkg::CFG_BITS-1:0] pick_wide();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return sstd_pkg::CFG_BITS'($urandom_range(0, 255));
            default: return sstd_pkg::CFG_BITS'($urandom_range(0, (1 << sstd_pkg::CFG_BITS) - 1));
        endcase
    endfunction

    initial begin
        int ph;
        int n;
        int s;
        queue_sample(0);
        queue_sample(1023);
        queue_sample(324);
        queue_sample(325);
        queue_sample(10'h2AA);
        queue_sample(10'h155);
        queue_write(sstd_pkg::REG_RADIX, sstd_pkg::CFG_BITS'(sstd_pkg::BASE_MIN));
        queue_write(sstd_pkg::REG_GAIN, '1);
        queue_write(sstd_pkg::REG_OFFSET, '0);
        queue_sample(1023);
        queue_sample(0);
        queue_sample(1);
        queue_write(sstd_pkg::REG_OFFSET, '1);
        queue_sample(0);
        queue_sample(1023);
        queue_write(sstd_pkg::REG_RADIX, 18'h3FFF0);
        queue_sample(0);
        queue_write(sstd_pkg::REG_RADIX, 18'h0000F);
        queue_sample(0);
        queue_write(REG_NONE, 18'h00007);
        queue_write(sstd_pkg::REG_GAIN, '0);
        queue_sample(512);
        queue_write(sstd_pkg::REG_GAIN, 18'd1);
        queue_write(sstd_pkg::REG_OFFSET, 18'd1000);
        queue_sample(3);
        queue_write(sstd_pkg::REG_RADIX, sstd_pkg::CFG_BITS'(sstd_pkg::BASE_DEC));
        queue_write(sstd_pkg::REG_GAIN, '1);
        queue_write(sstd_pkg::REG_OFFSET, '0);
        queue_sample(1023);

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 0 || $urandom_range(0, 1)) queue_write(sstd_pkg::REG_OFFSET, pick_wide());
            if (ph == 0 || $urandom_range(0, 1)) queue_write(sstd_pkg::REG_GAIN, pick_wide());
            if (ph == 0 || $urandom_range(0, 1)) begin
                queue_write(sstd_pkg::REG_RADIX,
                            {14'($urandom_range(0, 16383)), 4'($urandom_range(0, 15))});
            end
            if ($urandom_range(0, 3) == 0) queue_write(REG_NONE, pick_wide());
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    s = int'(gen_offset >> 8) + int'($urandom_range(0, 6)) - 3;
                    if (s < 0) s = 0;
                    if (s > 1023) s = 1023;
                end else begin
                    s = int'($urandom_range(0, 1023));
                end
                queue_sample(s);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (work_q.size() != 0 || text_q.size() != 0 || busy || start) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
design/sstd_pkg.sv
design/sensor_sample_to_decimal_text.sv
tb/sv/sensor_sample_to_decimal_text_tb.sv
